[rtl/rsst_pkg.sv]
`default_nettype none

package rsst_pkg;

  localparam int POS_W      = 11;
  localparam int DATA_W     = 64;
  localparam int IN_TDATA_W = 88;
  localparam int UPC_W      = 4;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_SUM = 1'b1;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_IDLE     = 4'd0;
  localparam upc_t U_CLR      = 4'd1;
  localparam upc_t U_CLR_END  = 4'd2;
  localparam upc_t U_SET_WR   = 4'd3;
  localparam upc_t U_SET_RD   = 4'd4;
  localparam upc_t U_SET_UP   = 4'd5;
  localparam upc_t U_SET_END  = 4'd6;
  localparam upc_t U_SUM_LOOP = 4'd7;
  localparam upc_t U_SUM_RDHI = 4'd8;
  localparam upc_t U_SUM_STEP = 4'd9;
  localparam upc_t U_EMIT     = 4'd10;

  typedef enum logic [1:0] {A_K, A_K_SIB, A_K_PAR, A_HI_M1} addr_sel_t;
  typedef enum logic [2:0] {M_NONE, M_RD, M_WR_ZERO, M_WR_ACC, M_WR_SUM} mem_op_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_ADD, ACC_ADD_LO, ACC_ADD_HI} acc_op_t;
  typedef enum logic [1:0] {P_HOLD, P_INC, P_PAR, P_STEP} ptr_op_t;
  typedef enum logic [2:0] {C_NEXT, C_ALWAYS, C_CLR_MORE, C_PAR_NOT_ROOT, C_LO_GE_HI} cond_t;

  typedef struct packed {
    addr_sel_t addr;
    mem_op_t   mem;
    acc_op_t   acc;
    ptr_op_t   ptr;
    logic      emit;
    cond_t     cond;
    upc_t      target;
  } uword_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{addr: A_K, mem: M_NONE, acc: ACC_HOLD, ptr: P_HOLD, emit: 1'b0,
          cond: C_ALWAYS, target: U_IDLE};
    unique case (pc)
      U_IDLE: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_CLR: begin
        w.mem    = M_WR_ZERO;
        w.ptr    = P_INC;
        w.cond   = C_CLR_MORE;
        w.target = U_CLR;
      end
      U_CLR_END: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_SET_WR: begin
        w.mem  = M_WR_ACC;
        w.cond = C_NEXT;
      end
      U_SET_RD: begin
        w.addr = A_K_SIB;
        w.mem  = M_RD;
        w.cond = C_NEXT;
      end
      U_SET_UP: begin
        w.addr   = A_K_PAR;
        w.mem    = M_WR_SUM;
        w.acc    = ACC_ADD;
        w.ptr    = P_PAR;
        w.cond   = C_PAR_NOT_ROOT;
        w.target = U_SET_RD;
      end
      U_SET_END: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_SUM_LOOP: begin
        w.mem    = M_RD;
        w.cond   = C_LO_GE_HI;
        w.target = U_EMIT;
      end
      U_SUM_RDHI: begin
        w.addr = A_HI_M1;
        w.mem  = M_RD;
        w.acc  = ACC_ADD_LO;
        w.cond = C_NEXT;
      end
      U_SUM_STEP: begin
        w.acc    = ACC_ADD_HI;
        w.ptr    = P_STEP;
        w.cond   = C_ALWAYS;
        w.target = U_SUM_LOOP;
      end
      U_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/range_sum_segment_tree_unit.sv]
// Set: writes the leaf, then per level up to the root reads the sibling and writes the sum.
// Sum: per tree level reads the low and high border nodes and adds the ones in the range,
// then a final range test and a step to load the result; an empty range goes straight to the load.
// One item at a time on the single-port node memory; a waiting result stalls the next
// sum at its load step, and input with it. Reset (rst, synchronous): a clearing pass
// zeroes every node slot; s_axis_tready stays low until it is done.
`default_nettype none

module range_sum_segment_tree_unit #(
  parameter int LEAF_COUNT = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // position [10:0], right_end [21:11], new_value [85:22], zero pad [87:86]
  input  wire logic [rsst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation [0]
  input  wire logic [0:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // range_sum [63:0]
  output logic [rsst_pkg::DATA_W-1:0]           m_axis_tdata
);

  localparam int DEPTH = 2 * LEAF_COUNT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int NW    = IDX_W + 1;
  localparam int CW    = (NW > rsst_pkg::POS_W) ? NW : rsst_pkg::POS_W;
  localparam int PW    = rsst_pkg::POS_W;
  localparam int DW    = rsst_pkg::DATA_W;

  rsst_pkg::upc_t   upc;
  rsst_pkg::upc_t   upc_next;
  rsst_pkg::uword_t uw;

  logic [NW-1:0] k;
  logic [NW-1:0] hi;
  logic [DW-1:0] acc;
  logic [DW-1:0] rdata;
  logic [DW-1:0] acc_sum;
  logic [DW-1:0] wdata;
  logic [NW-1:0] addr_full;
  logic [IDX_W-1:0] mem_addr;
  logic [NW-1:0] k_par;

  logic [DW-1:0] node_mem [DEPTH];

  logic          accept;
  logic          op_sum;
  logic [CW-1:0] leaf_cnt_c;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] right_w;
  logic [CW-1:0] left_c;
  logic [CW-1:0] right_c;
  logic [CW-1:0] leaf_idx;
  logic [CW-1:0] lo_init;
  logic [CW-1:0] hi_init;
  logic          set_bad;
  logic          sum_bad;
  logic          stall;
  logic          emit_fire;
  logic          jump;

  assign uw     = rsst_pkg::ucode(upc);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign op_sum = (s_axis_tuser[0] == rsst_pkg::OP_SUM);

  // request decode and range clipping
  assign leaf_cnt_c = CW'(LEAF_COUNT);
  assign pos_c      = CW'(s_axis_tdata[PW-1:0]);
  assign right_w    = CW'(s_axis_tdata[2*PW-1:PW]);
  assign set_bad    = (pos_c == '0) || (pos_c > leaf_cnt_c);
  assign left_c     = (pos_c == '0) ? CW'(1) : pos_c;
  assign right_c    = (right_w > leaf_cnt_c) ? leaf_cnt_c : right_w;
  assign sum_bad    = left_c > right_c;
  assign leaf_idx   = leaf_cnt_c + pos_c - CW'(1);
  assign lo_init    = left_c - CW'(1) + leaf_cnt_c;
  assign hi_init    = right_c + leaf_cnt_c;

  assign k_par   = k >> 1;
  assign acc_sum = acc + rdata;

  always_comb begin
    case (uw.addr)
      rsst_pkg::A_K_SIB: addr_full = k ^ NW'(1);
      rsst_pkg::A_K_PAR: addr_full = k_par;
      rsst_pkg::A_HI_M1: addr_full = hi - NW'(1);
      default:           addr_full = k;
    endcase
  end
  assign mem_addr = addr_full[IDX_W-1:0];

  always_comb begin
    case (uw.mem)
      rsst_pkg::M_WR_ACC: wdata = acc;
      rsst_pkg::M_WR_SUM: wdata = acc_sum;
      default:            wdata = '0;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      rsst_pkg::C_ALWAYS:       jump = 1'b1;
      rsst_pkg::C_CLR_MORE:     jump = (k != NW'(DEPTH - 1));
      rsst_pkg::C_PAR_NOT_ROOT: jump = (k_par != NW'(1));
      rsst_pkg::C_LO_GE_HI:     jump = (k >= hi);
      default:                  jump = 1'b0;
    endcase
  end

  assign stall     = uw.emit && m_axis_tvalid && !m_axis_tready;
  assign emit_fire = uw.emit && !stall;

  always_comb begin
    if (upc == rsst_pkg::U_IDLE) begin
      if (!accept) begin
        upc_next = rsst_pkg::U_IDLE;
      end else if (op_sum) begin
        upc_next = sum_bad ? rsst_pkg::U_EMIT : rsst_pkg::U_SUM_LOOP;
      end else begin
        upc_next = set_bad ? rsst_pkg::U_IDLE : rsst_pkg::U_SET_WR;
      end
    end else if (stall) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + rsst_pkg::upc_t'(1);
    end
  end

  assign s_axis_tready = (upc == rsst_pkg::U_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= rsst_pkg::U_CLR;
    end else begin
      upc <= upc_next;
    end
  end

  // walk pointers; k doubles as the clear counter after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (accept) begin
      k   <= op_sum ? lo_init[NW-1:0] : leaf_idx[NW-1:0];
      hi  <= hi_init[NW-1:0];
      acc <= op_sum ? '0 : s_axis_tdata[2*PW+DW-1:2*PW];
    end else begin
      case (uw.ptr)
        rsst_pkg::P_INC:  k <= k + NW'(1);
        rsst_pkg::P_PAR:  k <= k_par;
        rsst_pkg::P_STEP: begin
          k  <= (k + NW'(k[0])) >> 1;
          hi <= (hi - NW'(hi[0])) >> 1;
        end
        default: ;
      endcase
      case (uw.acc)
        rsst_pkg::ACC_ADD:    acc <= acc_sum;
        rsst_pkg::ACC_ADD_LO: if (k[0]) acc <= acc_sum;
        rsst_pkg::ACC_ADD_HI: if (hi[0]) acc <= acc_sum;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (uw.mem == rsst_pkg::M_RD) begin
      rdata <= node_mem[mem_addr];
    end else if (uw.mem != rsst_pkg::M_NONE) begin
      node_mem[mem_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) m_axis_tdata <= acc;
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input ready right after reset");

  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !op_sum && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("set item produced a result");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(upc) == rsst_pkg::U_EMIT))
    else $error("result raised outside the emit step");

  a_no_node_zero: assert property (@(posedge clk) disable iff (rst)
    (upc != rsst_pkg::U_CLR && uw.mem != rsst_pkg::M_NONE) |-> (mem_addr != '0))
    else $error("walk touched unused node slot");

  a_hi_bound: assert property (@(posedge clk) disable iff (rst)
    (upc == rsst_pkg::U_SUM_LOOP) |-> (hi <= NW'(DEPTH)))
    else $error("range end beyond tree");

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;

  localparam int LEAVES      = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int NUM_PROBES  = 20;
  localparam int POS_W       = rsst_pkg::POS_W;
  localparam int DATA_W      = rsst_pkg::DATA_W;
  localparam int IN_TDATA_W  = rsst_pkg::IN_TDATA_W;

  typedef struct packed {
    logic              op;
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  right;
    logic [DATA_W-1:0] value;
    logic              known;
    logic [DATA_W-1:0] sum;
  } probe_t;

  localparam logic [DATA_W-1:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [DATA_W-1:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] ALL_ONE = 64'hffff_ffff_ffff_ffff;

  // known = 1: sum is typed in; otherwise the tree predictor supplies it
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{rsst_pkg::OP_SUM, 11'd1,    11'd1024, 64'd0,                 1'b1, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd0,    11'd0,    64'd0,                 1'b1, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd2047, 11'd2047, 64'd0,                 1'b1, 64'd0},
    '{rsst_pkg::OP_SET, 11'd1,    11'd0,    MAX_POS,               1'b0, 64'd0},
    '{rsst_pkg::OP_SET, 11'd1024, 11'd2047, 64'd1,                 1'b0, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd1,    11'd1024, 64'd0,                 1'b1, MIN_NEG},
    '{rsst_pkg::OP_SUM, 11'd1024, 11'd1,    64'd0,                 1'b1, 64'd0},
    '{rsst_pkg::OP_SET, 11'd0,    11'd5,    ALL_ONE,               1'b0, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd0,    11'd0,    64'd0,                 1'b1, 64'd0},
    '{rsst_pkg::OP_SET, 11'd1025, 11'd1,    64'h1234_5678_9abc_def0, 1'b0, 64'd0},
    '{rsst_pkg::OP_SET, 11'd2047, 11'd2047, ALL_ONE,               1'b0, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd1,    11'd2047, 64'd0,                 1'b1, MIN_NEG},
    '{rsst_pkg::OP_SET, 11'd512,  11'd0,    MIN_NEG,               1'b0, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd512,  11'd512,  64'd0,                 1'b1, MIN_NEG},
    '{rsst_pkg::OP_SET, 11'd2,    11'd2047, ALL_ONE,               1'b0, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd1,    11'd2,    64'd0,                 1'b1, 64'h7fff_ffff_ffff_fffe},
    '{rsst_pkg::OP_SUM, 11'd1024, 11'd1024, 64'd0,                 1'b1, 64'd1},
    '{rsst_pkg::OP_SUM, 11'd1025, 11'd2047, 64'd0,                 1'b1, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd3,    11'd511,  64'd0,                 1'b1, 64'd0},
    '{rsst_pkg::OP_SUM, 11'd0,    11'd2047, 64'd0,                 1'b0, 64'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;

  logic [DATA_W-1:0] part_sums [2*LEAVES];
  logic [DATA_W-1:0] sums_due [$];
  logic [DATA_W-1:0] sum_want;
  int                fail_count = 0;
  int                stall_cycles = 0;
  int                src_idle = 0;
  int                dst_idle = 0;

  range_sum_segment_tree_unit #(.LEAF_COUNT(LEAVES)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // heap order, 1-based: root at 1, leaf p at LEAVES+p-1
  function automatic void part_sums_store(input logic [POS_W-1:0] pos,
                                          input logic [DATA_W-1:0] value);
    int k;
    if (pos < 1 || pos > LEAVES) return;
    k = LEAVES + int'(pos) - 1;
    part_sums[k] = value;
    while (k > 1) begin
      k = k >> 1;
      part_sums[k] = part_sums[2*k] + part_sums[2*k+1];
    end
  endfunction

  function automatic logic [DATA_W-1:0] part_sums_query(input logic [POS_W-1:0] left,
                                                        input logic [POS_W-1:0] right);
    int lo;
    int hi;
    logic [DATA_W-1:0] acc;
    acc = '0;
    lo = (left < 1) ? 1 : int'(left);
    hi = (right > LEAVES) ? LEAVES : int'(right);
    if (lo > hi) return acc;
    lo = lo - 1 + LEAVES;
    hi = hi + LEAVES;
    while (lo < hi) begin
      if ((lo & 1) != 0) begin
        acc = acc + part_sums[lo];
        lo++;
      end
      if ((hi & 1) != 0) begin
        hi--;
        acc = acc + part_sums[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    longint small_v;
    case ($urandom_range(9))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return ALL_ONE;
      3: return '0;
      4, 5: begin
        small_v = longint'($urandom_range(200)) - 100;
        return small_v;
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [POS_W-1:0] left,
                           input logic [POS_W-1:0] right, input logic [DATA_W-1:0] value,
                           input logic known, input logic [DATA_W-1:0] want);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, value, right, left};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == rsst_pkg::OP_SET) part_sums_store(left, value);
    else sums_due = {sums_due, (known ? want : part_sums_query(left, right))};
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sums_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    logic [POS_W-1:0] t;
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(9) == 0) a = POS_W'($urandom_range(2047));
        else a = POS_W'($urandom_range(LEAVES, 1));
        b = POS_W'($urandom);
        send_item(rsst_pkg::OP_SET, a, b, random_value(), 1'b0, '0);
      end else begin
        a = POS_W'($urandom_range(LEAVES, 1));
        b = POS_W'($urandom_range(LEAVES, 1));
        if (r < 90) begin
          if (a > b) begin
            t = a;
            a = b;
            b = t;
          end
        end else if (r < 95) begin
          a = POS_W'($urandom_range(2047));
          b = POS_W'($urandom_range(2047));
        end else if (a < b) begin
          t = a;
          a = b;
          b = t;
        end
        send_item(rsst_pkg::OP_SUM, a, b, random_value(), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sums_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        sum_want = sums_due.pop_front();
        if (sum_want !== m_axis_tdata) begin
          fail_count++;
          $display("%0t: range_sum mismatch, expected %h, actual %h",
                   $time, sum_want, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (part_sums[i]) part_sums[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    src_idle = 7;
    dst_idle = 50;
    foreach (PROBES[i]) begin
      send_item(PROBES[i].op, PROBES[i].left, PROBES[i].right, PROBES[i].value,
                PROBES[i].known, PROBES[i].sum);
    end
    drain_results();
    random_items(277);

    drain_results();
    src_idle = 50;
    dst_idle = 7;
    random_items(277);

    drain_results();
    src_idle = 0;
    dst_idle = 0;
    random_items(276);

    s_axis_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0 && sums_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/rsst_pkg.sv
rtl/range_sum_segment_tree_unit.sv
verif/testbench.sv
